// ===== src/lrap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lrap_pkg;

   // transaction kinds carried on req_tuser
   typedef enum logic [1:0] {
      OP_LOAD_BYTE = 2'd0,
      OP_SET_LEN   = 2'd1,
      OP_TEXT      = 2'd2,
      OP_NEW_TEXT  = 2'd3
   } opcode_type;

   localparam int OPCODE_W    = 2;
   localparam int BYTE_W      = 8;
   localparam int IDX_FIELD_W = 4;
   localparam int OFF_FIELD_W = 4;
   localparam int LEN_FIELD_W = 4;
   localparam int OUT_W       = 21;

   // request tdata layout, lowest bit first
   localparam int IDX_LO    = 0;
   localparam int OFF_LO    = IDX_LO + IDX_FIELD_W;
   localparam int BYTE_LO   = OFF_LO + OFF_FIELD_W;
   localparam int LEN_LO    = BYTE_LO + BYTE_W;
   localparam int IN_USED_W = LEN_LO + LEN_FIELD_W;
   localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

   // response tdata layout, lowest bit first
   localparam int OUT_USED_W  = 2 * OUT_W + 2;
   localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;
   localparam int OUT_PAD_W   = OUT_DATA_W - OUT_USED_W;

endpackage

`default_nettype wire

// ===== src/lrap_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrap_matcher #(
   parameter int NUM_PATTERNS    = 10,
   parameter int MAX_PATTERN_LEN = 10
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      byte_we,
   input  wire                                      len_we,
   input  wire [lrap_pkg::IDX_FIELD_W-1:0]          pattern_index,
   input  wire [lrap_pkg::OFF_FIELD_W-1:0]          pattern_offset,
   input  wire [lrap_pkg::BYTE_W-1:0]               data_byte,
   input  wire [lrap_pkg::LEN_FIELD_W-1:0]          pattern_length,
   input  wire [MAX_PATTERN_LEN-1:0][lrap_pkg::BYTE_W-1:0] window,
   input  wire [$clog2(MAX_PATTERN_LEN+1)-1:0]      fill,
   output logic                                     match_hit,
   output logic [$clog2(MAX_PATTERN_LEN+1)-1:0]     match_len
);

   import lrap_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
   localparam int SAT_W = LEN_FIELD_W + 1;

   logic [BYTE_W-1:0]       pat_ff [NUM_PATTERNS][MAX_PATTERN_LEN];
   logic [LEN_W-1:0]        len_ff [NUM_PATTERNS];
   logic [LEN_W-1:0]        len_sat;
   logic [NUM_PATTERNS-1:0] pat_match;
   logic [BYTE_W-1:0]       exp_byte;
   logic                    hit_at_len;

   // pattern byte store, no reset: the user must load the bytes before a pattern is enabled; not enforced here
   always_ff @(posedge clock) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
         for (int o = 0; o < MAX_PATTERN_LEN; o++) begin
            if (byte_we && pattern_index == IDX_FIELD_W'(p) &&
                pattern_offset == OFF_FIELD_W'(o)) begin
               pat_ff[p][o] <= data_byte;
            end
         end
      end
   end

   // lengths above the maximum clamp to the maximum
   assign len_sat = (SAT_W'(pattern_length) > SAT_W'(MAX_PATTERN_LEN)) ?
                    LEN_W'(MAX_PATTERN_LEN) : LEN_W'(pattern_length);

   // pattern lengths, zero disables a pattern
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PATTERNS; p++) begin
            len_ff[p] <= '0;
         end
      end else if (len_we) begin
         for (int p = 0; p < NUM_PATTERNS; p++) begin
            if (pattern_index == IDX_FIELD_W'(p)) begin
               len_ff[p] <= len_sat;
            end
         end
      end
   end

   // compare every enabled pattern against the newest bytes, last pattern byte vs newest
   always_comb begin
      exp_byte = '0;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
         pat_match[p] = 1'b1;
         for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
            exp_byte = '0;
            for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
               if (int'(len_ff[p]) == j + k + 1) begin
                  exp_byte = pat_ff[p][j];
               end
            end
            if (k < int'(len_ff[p]) && window[k] != exp_byte) begin
               pat_match[p] = 1'b0;
            end
         end
         if (len_ff[p] == '0 || len_ff[p] > fill) begin
            pat_match[p] = 1'b0;
         end
      end
   end

   // shortest matching length gives the latest match start
   always_comb begin
      match_len  = '0;
      hit_at_len = 1'b0;
      for (int l = MAX_PATTERN_LEN; l >= 1; l--) begin
         hit_at_len = 1'b0;
         for (int p = 0; p < NUM_PATTERNS; p++) begin
            if (pat_match[p] && int'(len_ff[p]) == l) begin
               hit_at_len = 1'b1;
            end
         end
         if (hit_at_len) begin
            match_len = LEN_W'(l);
         end
      end
      match_hit = |pat_match;
   end

endmodule

`default_nettype wire

// ===== src/longest_run_avoiding_patterns.sv =====
`timescale 1ns / 1ps
`default_nettype none
// longest run of text free of forbidden byte patterns
// req channel: one transaction per command, kind on req_tuser (load pattern byte,
// set pattern length, text byte, start new text), operands on req_tdata
// rsp channel: exactly one transaction per request, carrying the longest clean run
// length and start so far, a hit flag for the text byte and the overflow flag
// timing: a request is registered on acceptance and its response is registered
// when take moves it on, so rsp_tvalid follows after both pipeline registers
// throughput: one request per cycle while not stalled; all pattern compares for
// a text byte run in parallel in the matcher between the request register and
// the response register; when the receiver holds rsp_tready low the response
// register keeps its data and one more request is still taken into the request
// register; after that req_tready falls until the response is taken
// reset clears patterns lengths (all patterns disabled), the text window, position
// and run tracking and the overflow flag; pattern bytes are not cleared and must be
// loaded before their pattern is given a length
// text position saturates at MAX_TEXT: further text bytes are dropped and overflow set

module longest_run_avoiding_patterns #(
   parameter int              NUM_PATTERNS    = 10,
   parameter int              MAX_PATTERN_LEN = 10,
   parameter longint unsigned MAX_TEXT        = 64'd1048576
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [3:0] pattern_index, [7:4] pattern_offset, [15:8] data_byte,
   // [19:16] pattern_length, [23:20] zero
   input  wire [lrap_pkg::IN_DATA_W-1:0]       req_tdata,
   // [1:0] opcode
   input  wire [lrap_pkg::OPCODE_W-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [20:0] best_length, [41:21] best_start, [42] forbidden_hit, [43] overflow,
   // [47:44] zero
   output logic [lrap_pkg::OUT_DATA_W-1:0]     rsp_tdata
);

   import lrap_pkg::*;

   localparam int POS_W = $clog2(MAX_TEXT + 64'd1);
   localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);

   // request register
   logic                   in_valid_ff;
   opcode_type             in_op_ff;
   logic [IDX_FIELD_W-1:0] in_idx_ff;
   logic [OFF_FIELD_W-1:0] in_off_ff;
   logic [BYTE_W-1:0]      in_byte_ff;
   logic [LEN_FIELD_W-1:0] in_len_ff;
   logic                   take;

   // text state
   logic [MAX_PATTERN_LEN-1:0][BYTE_W-1:0] win_ff, win_in, win_shift;
   logic [LEN_W-1:0] fill_ff, fill_in, fill_shift;
   logic [POS_W-1:0] pos_ff, pos_in, pos_inc;
   logic [POS_W-1:0] allowed_ff, allowed_in;
   logic [POS_W-1:0] run_ff, run_in, run_inc;
   logic [POS_W-1:0] longest_ff, longest_in;
   logic [POS_W-1:0] longest_start_ff, longest_start_in;
   logic             overflow_ff, overflow_in;
   logic             hit_in;

   // match results
   logic             match_hit;
   logic [LEN_W-1:0] match_len;
   logic [POS_W-1:0] cut_run;
   logic [POS_W-1:0] cut_start;
   logic             cut;
   logic             saturated;

   // response register
   logic             out_valid_ff;
   logic [OUT_W-1:0] out_length_ff;
   logic [OUT_W-1:0] out_start_ff;
   logic             out_hit_ff;
   logic             out_overflow_ff;

   // pipeline flow control
   assign take       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || take;

   // request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= opcode_type'(req_tuser);
         in_idx_ff  <= req_tdata[IDX_LO +: IDX_FIELD_W];
         in_off_ff  <= req_tdata[OFF_LO +: OFF_FIELD_W];
         in_byte_ff <= req_tdata[BYTE_LO +: BYTE_W];
         in_len_ff  <= req_tdata[LEN_LO +: LEN_FIELD_W];
      end
   end

   // window with the new byte shifted in at the newest end
   always_comb begin
      win_shift[0] = in_byte_ff;
      for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
         win_shift[k] = win_ff[k-1];
      end
   end

   assign fill_shift = (fill_ff == LEN_W'(MAX_PATTERN_LEN)) ? fill_ff : fill_ff + LEN_W'(1);

   lrap_matcher #(
      .NUM_PATTERNS    (NUM_PATTERNS),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_matcher (
      .clock          (clock),
      .reset          (reset),
      .byte_we        (take && in_op_ff == OP_LOAD_BYTE),
      .len_we         (take && in_op_ff == OP_SET_LEN),
      .pattern_index  (in_idx_ff),
      .pattern_offset (in_off_ff),
      .data_byte      (in_byte_ff),
      .pattern_length (in_len_ff),
      .window         (win_shift),
      .fill           (fill_shift),
      .match_hit      (match_hit),
      .match_len      (match_len)
   );

   // a match cuts the clean run back to the bytes after the match start
   assign saturated = (pos_ff == POS_W'(MAX_TEXT));
   assign pos_inc   = pos_ff + POS_W'(1);
   assign run_inc   = run_ff + POS_W'(1);
   assign cut_run   = POS_W'(match_len) - POS_W'(1);
   assign cut_start = pos_inc - cut_run;
   assign cut       = match_hit && (cut_run < run_inc);

   // next text state
   always_comb begin
      win_in           = win_ff;
      fill_in          = fill_ff;
      pos_in           = pos_ff;
      allowed_in       = allowed_ff;
      run_in           = run_ff;
      longest_in       = longest_ff;
      longest_start_in = longest_start_ff;
      overflow_in      = overflow_ff;
      hit_in           = 1'b0;
      case (in_op_ff)
         OP_TEXT: begin
            if (saturated) begin
               overflow_in = 1'b1;
            end else begin
               win_in  = win_shift;
               fill_in = fill_shift;
               pos_in  = pos_inc;
               hit_in  = match_hit;
               if (cut) begin
                  run_in     = cut_run;
                  allowed_in = cut_start;
               end else begin
                  run_in = run_inc;
               end
               if (run_in > longest_ff) begin
                  longest_in       = run_in;
                  longest_start_in = allowed_in;
               end
            end
         end
         OP_NEW_TEXT: begin
            win_in           = '0;
            fill_in          = '0;
            pos_in           = '0;
            allowed_in       = '0;
            run_in           = '0;
            longest_in       = '0;
            longest_start_in = '0;
            overflow_in      = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // text state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff           <= '0;
         fill_ff          <= '0;
         pos_ff           <= '0;
         allowed_ff       <= '0;
         run_ff           <= '0;
         longest_ff       <= '0;
         longest_start_ff <= '0;
         overflow_ff      <= 1'b0;
      end else if (take) begin
         win_ff           <= win_in;
         fill_ff          <= fill_in;
         pos_ff           <= pos_in;
         allowed_ff       <= allowed_in;
         run_ff           <= run_in;
         longest_ff       <= longest_in;
         longest_start_ff <= longest_start_in;
         overflow_ff      <= overflow_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_length_ff   <= OUT_W'(longest_in);
         out_start_ff    <= OUT_W'(longest_start_in);
         out_hit_ff      <= hit_in;
         out_overflow_ff <= overflow_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{OUT_PAD_W{1'b0}}, out_overflow_ff, out_hit_ff,
                        out_start_ff, out_length_ff};

   // the clean run always ends at the current position
   a_run_tracks_position: assert property (@(posedge clock) disable iff (reset)
      allowed_ff + run_ff == pos_ff)
      else $error("clean run and allowed start disagree with position");

   // the best run never exceeds the text seen
   a_longest_bounded: assert property (@(posedge clock) disable iff (reset)
      longest_ff <= pos_ff && longest_start_ff + longest_ff <= pos_ff)
      else $error("best run reaches past the text position");

   // overflow only once the position has saturated
   a_overflow_saturated: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> pos_ff == POS_W'(MAX_TEXT))
      else $error("overflow set below the position limit");

   // a hit is only reported for a text byte
   a_hit_text_only: assert property (@(posedge clock) disable iff (reset)
      (take && in_op_ff != OP_TEXT) |=> !out_hit_ff)
      else $error("hit reported for a non-text transaction");

endmodule

`default_nettype wire

// ===== test/longest_run_avoiding_patterns_tb.sv =====
`timescale 1ns / 1ps

module longest_run_avoiding_patterns_tb;
   import lrap_pkg::*;

   localparam int              NPAT        = 10;
   localparam int              PLEN        = 10;
   localparam longint unsigned TEXT_LIMIT  = 64'd1048576;
   localparam int              LOAD_REQS   = NPAT * PLEN;
   localparam int              RANDOM_REQS = 1300;
   localparam int              TOTAL_REQS  = LOAD_REQS + RANDOM_REQS;
   localparam int              CYCLE_LIMIT = 200000;

   // one command as queued for the driver, plus its pacing
   typedef struct packed {
      opcode_type  op;
      logic [3:0]  idx;
      logic [3:0]  off;
      logic [7:0]  data;
      logic [3:0]  len;
      logic [2:0]  gap;
      logic        drain;
   } req_item_type;

   typedef struct packed {
      logic [OUT_W-1:0] best_length;
      logic [OUT_W-1:0] best_start;
      logic             hit;
      logic             ovf;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [IN_DATA_W-1:0] req_tdata;
   logic [OPCODE_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [OUT_DATA_W-1:0] rsp_tdata;

   // predictor state
   logic [7:0]      m_recent [PLEN];
   logic [7:0]      m_pat    [NPAT][PLEN];
   int unsigned     m_len    [NPAT];
   longint unsigned m_pos;
   longint unsigned m_allowed;
   longint unsigned m_longest;
   longint unsigned m_lstart;
   logic            m_ovf;

   // queues between stimulus, driver and monitor
   req_item_type pending [$];
   rsp_item_type exp_q [$];

   // handshake bookkeeping
   int         cycle_cnt;
   int         sent_cnt;
   int         recv_cnt;
   int         err_cnt;
   logic       req_took;
   logic       rsp_took;
   logic [2:0] drv_idle;
   logic       drv_armed;
   logic [2:0] rcv_idle;

   longest_run_avoiding_patterns dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // predictor: clear text tracking, patterns are kept
   task automatic model_clear();
      for (int k = 0; k < PLEN; k++) begin
         m_recent[k] = 8'h00;
      end
      m_pos     = 64'd0;
      m_allowed = 64'd0;
      m_longest = 64'd0;
      m_lstart  = 64'd0;
      m_ovf     = 1'b0;
   endtask

   task automatic model_reset();
      for (int p = 0; p < NPAT; p++) begin
         m_len[p] = 0;
         for (int o = 0; o < PLEN; o++) begin
            m_pat[p][o] = 8'h00;
         end
      end
      model_clear();
   endtask

   // predictor: one transaction in, one expected result out
   task automatic model_step(input req_item_type it, output rsp_item_type r);
      longint unsigned npos;
      longint unsigned mstart;
      int unsigned     plen;
      logic            hit;
      logic            ok;
      hit = 1'b0;
      case (it.op)
         OP_LOAD_BYTE: begin
            if (int'(it.idx) < NPAT && int'(it.off) < PLEN) begin
               m_pat[it.idx][it.off] = it.data;
            end
         end
         OP_SET_LEN: begin
            if (int'(it.idx) < NPAT) begin
               m_len[it.idx] = (int'(it.len) > PLEN) ? PLEN : int'(it.len);
            end
         end
         OP_TEXT: begin
            if (m_pos >= TEXT_LIMIT) begin
               m_ovf = 1'b1;
            end else begin
               for (int k = PLEN - 1; k > 0; k--) begin
                  m_recent[k] = m_recent[k - 1];
               end
               m_recent[0] = it.data;
               npos = m_pos + 64'd1;
               for (int p = 0; p < NPAT; p++) begin
                  plen = m_len[p];
                  if (plen != 0 && 64'(plen) <= npos) begin
                     ok = 1'b1;
                     for (int k = 0; k < int'(plen); k++) begin
                        if (m_recent[k] != m_pat[p][int'(plen) - 1 - k]) begin
                           ok = 1'b0;
                        end
                     end
                     if (ok) begin
                        hit    = 1'b1;
                        mstart = npos - 64'(plen) + 64'd1;
                        if (mstart > m_allowed) begin
                           m_allowed = mstart;
                        end
                     end
                  end
               end
               if (npos - m_allowed > m_longest) begin
                  m_longest = npos - m_allowed;
                  m_lstart  = m_allowed;
               end
               m_pos = npos;
            end
         end
         default: begin
            model_clear();
         end
      endcase
      r.best_length = OUT_W'(m_longest);
      r.best_start  = OUT_W'(m_lstart);
      r.hit         = hit;
      r.ovf         = m_ovf;
   endtask

   // small alphabet so patterns actually show up in the text
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(9, 0) == 0) begin
         return 8'($urandom_range(255, 0));
      end
      return 8'(8'h61 + $urandom_range(3, 0));
   endfunction

   function automatic req_item_type make_item(int n);
      req_item_type it;
      int unsigned  sel;
      sel      = $urandom_range(99, 0);
      it.idx   = 4'($urandom_range(15, 0));
      it.off   = 4'($urandom_range(15, 0));
      it.data  = pick_byte();
      it.len   = 4'($urandom_range(15, 0));
      it.gap   = 3'($urandom_range(6, 0));
      it.drain = ((n % 250) == 125);
      if (sel < 62) begin
         it.op = OP_TEXT;
      end else if (sel < 74) begin
         it.op = OP_LOAD_BYTE;
      end else if (sel < 96) begin
         it.op = OP_SET_LEN;
         if ($urandom_range(9, 0) < 8) begin
            it.idx = 4'($urandom_range(NPAT - 1, 0));
            it.len = 4'($urandom_range(4, 0));
         end
      end else begin
         it.op = OP_NEW_TEXT;
      end
      return it;
   endfunction

   // stimulus, reset and end of run
   initial begin
      req_item_type it;
      rsp_item_type r;
      reset = 1'b1;
      model_reset();
      // load every pattern byte before any pattern is enabled
      for (int p = 0; p < NPAT; p++) begin
         for (int o = 0; o < PLEN; o++) begin
            it.op    = OP_LOAD_BYTE;
            it.idx   = 4'(p);
            it.off   = 4'(o);
            it.data  = pick_byte();
            it.len   = 4'd0;
            it.gap   = 3'($urandom_range(6, 0));
            it.drain = 1'b0;
            pending.push_back(it);
            model_step(it, r);
            exp_q.push_back(r);
         end
      end
      for (int n = 0; n < RANDOM_REQS; n++) begin
         it = make_item(n);
         pending.push_back(it);
         model_step(it, r);
         exp_q.push_back(r);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (recv_cnt < TOTAL_REQS && cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (err_cnt == 0 && recv_cnt == TOTAL_REQS && exp_q.size() == 0) begin
         $display("longest_run_avoiding_patterns_tb: done, clean");
      end else begin
         $display("longest_run_avoiding_patterns_tb: done, errors");
      end
      $finish;
   end

   // driver: present queued transactions at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         drv_idle   <= 3'd0;
         drv_armed  <= 1'b0;
      end else if (req_tvalid && !req_took) begin
         // hold the transaction until it is accepted
      end else if (drv_idle != 3'd0) begin
         req_tvalid <= 1'b0;
         drv_idle   <= drv_idle - 3'd1;
      end else if (pending.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (!drv_armed && pending[0].gap != 3'd0) begin
         req_tvalid <= 1'b0;
         drv_idle   <= pending[0].gap - 3'd1;
         drv_armed  <= 1'b1;
      end else if (pending[0].drain && sent_cnt != recv_cnt) begin
         // wait until every outstanding result is back
         req_tvalid <= 1'b0;
         drv_armed  <= 1'b1;
      end else begin
         req_tvalid <= 1'b1;
         req_tuser  <= pending[0].op;
         req_tdata  <= IN_DATA_W'({pending[0].len, pending[0].data,
                                   pending[0].off, pending[0].idx});
         drv_armed  <= 1'b0;
         void'(pending.pop_front());
      end
   end

   // receiver: idle cycles before each result
   always @(negedge clock) begin : rsp_pacing
      logic [2:0] draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         rcv_idle   <= 3'd0;
      end else if (rsp_took) begin
         draw = 3'($urandom_range(6, 0));
         if (draw == 3'd0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rcv_idle   <= draw - 3'd1;
         end
      end else if (rcv_idle != 3'd0) begin
         rcv_idle <= rcv_idle - 3'd1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: count handshakes and check results at the rising edge
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         cycle_cnt <= 0;
         sent_cnt  <= 0;
         recv_cnt  <= 0;
         err_cnt   <= 0;
         req_took  <= 1'b0;
         rsp_took  <= 1'b0;
      end else begin
         cycle_cnt <= cycle_cnt + 1;
         req_took  <= req_tvalid && req_tready;
         rsp_took  <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            sent_cnt <= sent_cnt + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            recv_cnt <= recv_cnt + 1;
            got.best_length = rsp_tdata[0 +: OUT_W];
            got.best_start  = rsp_tdata[OUT_W +: OUT_W];
            got.hit         = rsp_tdata[2 * OUT_W];
            got.ovf         = rsp_tdata[2 * OUT_W + 1];
            if (exp_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               err_cnt <= err_cnt + 1;
            end else begin
               want = exp_q.pop_front();
               if (got !== want) begin
                  $display("%0t: expected len %0d start %0d hit %0b ovf %0b",
                           $time, want.best_length, want.best_start, want.hit, want.ovf);
                  $display("%0t: actual   len %0d start %0d hit %0b ovf %0b",
                           $time, got.best_length, got.best_start, got.hit, got.ovf);
                  err_cnt <= err_cnt + 1;
               end
            end
         end
      end
   end

endmodule

// ===== sim.f =====
src/lrap_pkg.sv
src/lrap_matcher.sv
src/longest_run_avoiding_patterns.sv
test/longest_run_avoiding_patterns_tb.sv
